// ===== sv/rbo_pkg.sv =====
// Shared constants for the rank-biased overlap core.
// No dependencies; imported by every module of the block.
package rbo_pkg;
	localparam int unsigned ID_BITS_DEF   = 12;
	localparam int unsigned MAX_DEPTH_DEF = 1024;
	localparam int unsigned DECAY_W       = 16;
	localparam int unsigned CNT_W         = 11;
	localparam int unsigned VAL_W         = 17;
	localparam int unsigned POW_W         = 32;
	localparam int unsigned SUM_W         = 48;
	localparam int unsigned HALF_W        = SUM_W / 2;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
	localparam logic [POW_W-1:0]   POWER_ONE   = 32'hFFFF_FFFF;
	localparam logic [VAL_W-1:0]   UNIT_Q16    = 17'h1_0000;
endpackage

// ===== sv/rank_biased_overlap_core.sv =====
// Rank-biased overlap core: one ID pair per item, one result per list.
// Per pair: bitmap lookup on take, bitmap and log write, multiply, then the
// two-bit-per-cycle divider and accumulate; a last pair adds two finish steps, the result register and the erase.
// Flow: a new pair is taken only after the last one is done; a queue of two pairs takes input meanwhile.
// Reset: arst_n async; after reset an init pass clears every bitmap entry.
// Depends on rbo_pkg, rbo_front, rbo_back.
module rank_biased_overlap_core import rbo_pkg::*; #(
	parameter int unsigned ID_BITS   = ID_BITS_DEF,
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               decay_we,
	input  logic [DECAY_W-1:0] decay_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ID_BITS-1:0] a_id,
	input  logic [ID_BITS-1:0] b_id,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VAL_W-1:0]   rbo_value,
	output logic [CNT_W-1:0]   depth_count,
	output logic [CNT_W-1:0]   final_overlap
);
	logic [DECAY_W-1:0] decay_q;
	logic               q_valid, q_pop, q_last;
	logic [ID_BITS-1:0] q_a, q_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
		end else if (decay_we) begin
			decay_q <= decay_wdata;
		end
	end

	rbo_front #(.ID_BITS(ID_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .a_id, .b_id, .last_pair,
		.q_valid, .q_pop, .q_a, .q_b, .q_last
	);

	rbo_back #(.ID_BITS(ID_BITS), .MAX_DEPTH(MAX_DEPTH)) u_back (
		.clk, .arst_n, .decay(decay_q), .q_valid, .q_pop, .q_a, .q_b, .q_last,
		.out_valid, .out_stall, .rbo_value, .depth_count, .final_overlap
	);
endmodule

// ===== sv/rbo_front.sv =====
// Input side: a two-entry queue of ID pairs in front of the sequencer.
// Depends on rbo_pkg.
module rbo_front import rbo_pkg::*; #(
	parameter int unsigned ID_BITS = ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ID_BITS-1:0] a_id,
	input  logic [ID_BITS-1:0] b_id,
	input  logic               last_pair,
	output logic               q_valid,
	input  logic               q_pop,
	output logic [ID_BITS-1:0] q_a,
	output logic [ID_BITS-1:0] q_b,
	output logic               q_last
);
	localparam int unsigned EW = 2 * ID_BITS + 1;

	logic [EW-1:0] ent_q [QUEUE_DEPTH];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign in_stall = (cnt_q == 2'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign {q_a, q_b, q_last} = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= {a_id, b_id, last_pair};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== sv/rbo_back.sv =====
// Sequencer: seen-bitmaps, overlap count, weighted sum, radix-4 divider,
// result register and bitmap erase from an address log. Depends on rbo_pkg.
module rbo_back import rbo_pkg::*; #(
	parameter int unsigned ID_BITS   = ID_BITS_DEF,
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DECAY_W-1:0] decay,
	input  logic               q_valid,
	output logic               q_pop,
	input  logic [ID_BITS-1:0] q_a,
	input  logic [ID_BITS-1:0] q_b,
	input  logic               q_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VAL_W-1:0]   rbo_value,
	output logic [CNT_W-1:0]   depth_count,
	output logic [CNT_W-1:0]   final_overlap
);
	localparam int unsigned XW    = $clog2(MAX_DEPTH + 1);
	localparam int unsigned LOG_W = $clog2(MAX_DEPTH);
	localparam int unsigned IDS   = 1 << ID_BITS;
	localparam int unsigned DIV_CYC = POW_W / 2;
	localparam int unsigned DC_W  = $clog2(DIV_CYC);
	localparam int unsigned PROD_W = XW + POW_W;
	localparam int unsigned FULL_W = VAL_W + SUM_W;

	typedef enum logic [9:0] {
		S_INIT  = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_READ  = 10'b00_0000_0100,
		S_MUL   = 10'b00_0000_1000,
		S_DIV   = 10'b00_0001_0000,
		S_ACC   = 10'b00_0010_0000,
		S_FIN1  = 10'b00_0100_0000,
		S_FIN2  = 10'b00_1000_0000,
		S_OUT   = 10'b01_0000_0000,
		S_ERASE = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic                   seen_a_mem [IDS];
	logic                   seen_b_mem [IDS];
	logic [2*ID_BITS-1:0]   log_mem [MAX_DEPTH];

	logic [ID_BITS-1:0] a_q, b_q;
	logic               last_q;
	logic               hit_a_q, hit_b_q;
	logic [XW-1:0]      ovl_q, depth_q, x_q;
	logic [POW_W-1:0]   pow_q;
	logic [SUM_W-1:0]   sum_q;
	logic [XW-1:0]      rem_q;
	logic [POW_W-1:0]   quo_q;
	logic [DC_W-1:0]    dcnt_q;
	logic [ID_BITS-1:0] clr_q;
	logic [XW-1:0]      er_q;
	logic               er_s1;
	logic [2*ID_BITS-1:0] log_s1;
	logic [VAL_W+HALF_W-1:0] plo_q, phi_q;
	logic               ov_q;
	logic [VAL_W-1:0]   val_q;
	logic [CNT_W-1:0]   dc_q, fo_q;

	logic               take, rd_en, er_rd;
	logic [VAL_W-1:0]   one_minus;
	logic [XW+1:0]      x_sum;
	logic [XW-1:0]      x_new, d_new;
	logic [PROD_W-1:0]  prod;
	logic [POW_W+DECAY_W-1:0] pprod;
	logic [XW:0]        t1, t2, r1, r2;
	logic               ge1, ge2;
	logic [FULL_W-1:0]  full;

	assign one_minus = UNIT_Q16 - VAL_W'(decay);
	assign take  = (state_q == S_IDLE) && q_valid;
	assign q_pop = take;
	assign rd_en = take && (depth_q < XW'(MAX_DEPTH));
	assign er_rd = (state_q == S_ERASE) && (er_q < depth_q);

	// overlap grows by cross hits plus a direct match, held at the depth
	assign d_new = depth_q + XW'(1);
	assign x_sum = (XW+2)'(ovl_q) + (XW+2)'(hit_a_q) + (XW+2)'(hit_b_q)
		+ (XW+2)'(a_q == b_q);
	assign x_new = (x_sum > (XW+2)'(d_new)) ? d_new : x_sum[XW-1:0];

	assign prod  = PROD_W'(x_q) * PROD_W'(pow_q);
	assign pprod = (POW_W+DECAY_W)'(pow_q) * (POW_W+DECAY_W)'(decay);

	// two restoring steps per cycle
	assign t1  = {rem_q, quo_q[POW_W-1]};
	assign ge1 = (t1 >= {1'b0, depth_q});
	assign r1  = ge1 ? (t1 - {1'b0, depth_q}) : t1;
	assign t2  = {r1[XW-1:0], quo_q[POW_W-2]};
	assign ge2 = (t2 >= {1'b0, depth_q});
	assign r2  = ge2 ? (t2 - {1'b0, depth_q}) : t2;

	assign full = (FULL_W'(phi_q) << HALF_W) + FULL_W'(plo_q);

	// bitmap and log ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_a_q <= seen_a_mem[q_b];
			hit_b_q <= seen_b_mem[q_a];
		end
		if (state_q == S_INIT) begin
			seen_a_mem[clr_q] <= 1'b0;
			seen_b_mem[clr_q] <= 1'b0;
		end else if (state_q == S_READ) begin
			seen_a_mem[a_q] <= 1'b1;
			seen_b_mem[b_q] <= 1'b1;
		end else if (er_s1) begin
			seen_a_mem[log_s1[2*ID_BITS-1:ID_BITS]] <= 1'b0;
			seen_b_mem[log_s1[ID_BITS-1:0]]         <= 1'b0;
		end
		if (state_q == S_READ) begin
			log_mem[depth_q[LOG_W-1:0]] <= {a_q, b_q};
		end
		if (er_rd) begin
			log_s1 <= log_mem[er_q[LOG_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			a_q    <= q_a;
			b_q    <= q_b;
			last_q <= q_last;
		end
		if (state_q == S_READ) begin
			x_q <= x_new;
		end
		if (state_q == S_MUL) begin
			rem_q <= prod[PROD_W-1:POW_W];
			quo_q <= prod[POW_W-1:0];
		end else if (state_q == S_DIV) begin
			rem_q <= r2[XW-1:0];
			quo_q <= {quo_q[POW_W-3:0], ge1, ge2};
		end
		if (state_q == S_FIN1) begin
			plo_q <= (VAL_W+HALF_W)'(one_minus) * (VAL_W+HALF_W)'(sum_q[HALF_W-1:0]);
		end
		if (state_q == S_FIN2) begin
			phi_q <= (VAL_W+HALF_W)'(one_minus) * (VAL_W+HALF_W)'(sum_q[SUM_W-1:HALF_W]);
		end
		if (state_q == S_OUT && !ov_q) begin
			val_q <= full[POW_W+VAL_W-1:POW_W];
			dc_q  <= CNT_W'(depth_q);
			fo_q  <= CNT_W'(ovl_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q   <= '0;
			ovl_q   <= '0;
			depth_q <= '0;
			pow_q   <= POWER_ONE;
			sum_q   <= '0;
			dcnt_q  <= '0;
			er_q    <= '0;
			er_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			er_s1 <= er_rd;
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + ID_BITS'(1);
					if (clr_q == ID_BITS'(IDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (rd_en) begin
						state_q <= S_READ;
					end else if (take && q_last) begin
						state_q <= S_FIN1;
					end
				end
				S_READ: state_q <= S_MUL;
				S_MUL: begin
					pow_q   <= pprod[POW_W+DECAY_W-1:DECAY_W];
					ovl_q   <= x_q;
					depth_q <= d_new;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DC_W'(1);
					if (dcnt_q == DC_W'(DIV_CYC - 1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					sum_q   <= sum_q + SUM_W'(quo_q);
					state_q <= last_q ? S_FIN1 : S_IDLE;
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_OUT;
				S_OUT: begin
					// hold until the result register is free
					if (!ov_q) begin
						ov_q    <= 1'b1;
						er_q    <= '0;
						state_q <= S_ERASE;
					end
				end
				S_ERASE: begin
					if (er_rd) begin
						er_q <= er_q + XW'(1);
					end else if (!er_s1) begin
						ovl_q   <= '0;
						depth_q <= '0;
						pow_q   <= POWER_ONE;
						sum_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = ov_q;
	assign rbo_value     = val_q;
	assign depth_count   = dc_q;
	assign final_overlap = fo_q;
endmodule

// ===== sv/rbo_checker.sv =====
// Port-level checks on the result channel of rank_biased_overlap_core.
// Depends on rbo_pkg; bound to the top level below.
module rbo_checker import rbo_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [VAL_W-1:0] rbo_value,
	input logic [CNT_W-1:0] depth_count,
	input logic [CNT_W-1:0] final_overlap
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rbo_value)
			&& $stable(depth_count) && $stable(final_overlap))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rbo_value <= UNIT_Q16)
		else $error("overlap value above one");

	a_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> final_overlap <= depth_count)
		else $error("overlap exceeds depth");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> depth_count != '0)
		else $error("result with no depth");
endmodule

bind rank_biased_overlap_core rbo_checker u_rbo_checker (
	.clk, .arst_n, .out_valid, .out_stall, .rbo_value, .depth_count, .final_overlap
);
